// ----- design/dstwr_pkg.sv -----
// Package for the DS-TWR ranging responder: constants, status codes, shared types.
// No dependencies.
package dstwr_pkg;
    localparam int PacketBytes = 17;
    localparam logic [19:0] TofScaleQ16 = 20'd314764;
    localparam logic [4:0] CountSat = 5'd18;
    localparam logic [31:0] ReplyDelayRst = 32'd771204000;
    localparam logic [19:0] MaxDistRst = 20'd102400;

    typedef enum logic [1:0] {
        ST_REPLY  = 2'd0,
        ST_BADLEN = 2'd1,
        ST_PARITY = 2'd2,
        ST_DONE   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_INIT  = 2'd0,
        CFG_DELAY = 2'd1,
        CFG_MAXD  = 2'd2
    } t_cfg_idx;

    // Handshake between the sequencer and the distance unit.
    typedef struct packed {
        logic start;
    } t_dist_req;

    typedef struct packed {
        logic done;
        logic dv;
    } t_dist_rsp;
endpackage

// ----- design/dstwr_dist.sv -----
// Bit-serial DS-TWR distance unit: shift-add multipliers and restoring divider.
// Depends on dstwr_pkg.
module dstwr_dist
    import dstwr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dist_req   i_req,
    input  logic [31:0] i_ra,
    input  logic [31:0] i_rb,
    input  logic [31:0] i_da,
    input  logic [31:0] i_db,
    input  logic [19:0] i_max,
    output t_dist_rsp   o_rsp,
    output logic [19:0] o_dist
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_MUL1 = 6'b000010, S_MUL2 = 6'b000100,
        S_MUL3 = 6'b001000, S_DIV  = 6'b010000, S_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_acc, n_acc;     // multiplier accumulator
    logic [63:0] r_mcand, n_mcand;
    logic [31:0] r_mplier, n_mplier;
    logic [63:0] r_p, n_p;         // ra*rb
    logic [33:0] r_sum, n_sum;
    logic [83:0] r_num, n_num;     // scaled numerator, shifted out MSB first
    logic [50:0] r_rem, n_rem;
    logic        r_over, n_over;
    logic [31:0] r_quo, n_quo;
    logic        r_bad, n_bad;
    logic        r_done, n_done;
    logic        r_dv, n_dv;
    logic [19:0] r_dist, n_dist;

    logic [63:0] w_add;
    logic [51:0] w_sh;
    logic [50:0] w_div;
    logic [6:0]  w_bitpos;

    assign w_add  = r_mplier[0] ? r_acc + r_mcand : r_acc;
    assign w_div  = {1'b0, r_sum, 16'd0};
    assign w_sh   = {r_rem, r_num[83]};
    assign w_bitpos = 7'd83 - r_cnt;

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_acc = r_acc; n_mcand = r_mcand;
        n_mplier = r_mplier; n_p = r_p; n_sum = r_sum; n_num = r_num;
        n_rem = r_rem; n_over = r_over; n_quo = r_quo; n_bad = r_bad;
        n_done = 1'b0; n_dv = r_dv; n_dist = r_dist;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_state  = S_MUL1;
                    n_cnt    = '0;
                    n_acc    = '0;
                    n_mcand  = {32'd0, i_ra};
                    n_mplier = i_rb;
                    n_sum    = {2'b0, i_ra} + {2'b0, i_rb} + {2'b0, i_da} + {2'b0, i_db};
                end
            end
            S_MUL1: begin
                n_acc = w_add; n_mcand = {r_mcand[62:0], 1'b0};
                n_mplier = {1'b0, r_mplier[31:1]}; n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd31) begin
                    n_p = w_add; n_acc = '0; n_cnt = '0;
                    n_mcand = {32'd0, i_da}; n_mplier = i_db;
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                n_acc = w_add; n_mcand = {r_mcand[62:0], 1'b0};
                n_mplier = {1'b0, r_mplier[31:1]}; n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd31) begin
                    // Numerator must be positive and the time sum nonzero.
                    n_bad = (r_p <= w_add) || (r_sum == '0);
                    n_mcand = r_p - w_add;
                    n_acc = '0; n_cnt = '0;
                    n_mplier = {12'd0, TofScaleQ16};
                    n_num = '0;
                    n_state = S_MUL3;
                end
            end
            S_MUL3: begin
                // Scale multiply over 20 bits of the constant into 84 bits.
                if (r_mplier[0])
                    n_num = r_num + ({20'd0, r_mcand} << r_cnt[4:0]);
                n_mplier = {1'b0, r_mplier[31:1]}; n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd19) begin
                    n_cnt = '0; n_rem = '0; n_over = 1'b0; n_quo = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_num = {r_num[82:0], 1'b0};
                n_cnt = r_cnt + 7'd1;
                if (w_sh >= {1'b0, w_div}) begin
                    n_rem = 51'(w_sh - {1'b0, w_div});
                    if (w_bitpos >= 7'd32) n_over = 1'b1;
                    n_quo = {r_quo[30:0], 1'b1};
                end else begin
                    n_rem = w_sh[50:0];
                    n_quo = {r_quo[30:0], 1'b0};
                end
                if (r_cnt == 7'd83) n_state = S_FIN;
            end
            S_FIN: begin
                n_dv = !r_bad && !r_over && (r_quo != '0) && (r_quo < {12'd0, i_max});
                n_dist = n_dv ? r_quo[19:0] : '0;
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_done <= 1'b0;
        end else begin
            r_state <= n_state; r_done <= n_done;
        end
        r_cnt <= n_cnt; r_acc <= n_acc; r_mcand <= n_mcand; r_mplier <= n_mplier;
        r_p <= n_p; r_sum <= n_sum; r_num <= n_num; r_rem <= n_rem;
        r_over <= n_over; r_quo <= n_quo; r_bad <= n_bad; r_dv <= n_dv;
        r_dist <= n_dist;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.dv   = r_dv;
    assign o_dist     = r_dist;
endmodule

// ----- design/ds_twr_ranging_responder.sv -----
// DS-TWR ranging responder top level: parser, sequencer, reply emitter; uses dstwr_pkg, dstwr_dist.
// A rejected packet's status transaction is offered in the cycle after its final byte; a reply to
// packets 0 to 2 is offered once S_CALC is done, and packets numbered 3 or more wait in S_WAIT for
// the bit-serial distance unit (two 32-bit multiplies, a 20-bit scale multiply, an 84-bit divide).
// Reply bytes advance while i_ready; input bytes wait until a packet's last result is gone.
// Reset is synchronous, active low: control state, packet words, schedule and configuration reload.
module ds_twr_ranging_responder
    import dstwr_pkg::*;
#(
    parameter int PACKET_BYTES = PacketBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_rx_last,
    input  logic [39:0] i_rx_time,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_valid,
    output logic        o_tx_last,
    output logic [31:0] o_tx_start_time,
    output logic [19:0] o_distance_q10,
    output logic        o_distance_valid,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    // The sequencer is one-hot: receive bytes; for a packet that passes its checks, compute
    // or wait on the distance unit, then emit the single status transaction or the reply bytes.
    typedef enum logic [3:0] {
        S_RX   = 4'b0001,
        S_CALC = 4'b0010,
        S_WAIT = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic        r_is_init;
    logic [31:0] r_delay;
    logic [19:0] r_maxd;
    logic [4:0]  r_cnt, n_cnt;
    logic [7:0]  r_seq, n_seq;
    logic [31:0] r_pround, n_pround, r_pdelay, n_pdelay, r_eown, n_eown;
    logic [39:0] r_sched, n_sched;
    logic [39:0] r_rxt, n_rxt;
    logic [31:0] r_round, n_round;
    logic [31:0] r_own, n_own;
    logic [1:0]  r_st, n_st;
    logic [4:0]  r_oidx, n_oidx;
    logic        r_oval, n_oval;
    logic        r_multi, n_multi;
    logic [19:0] r_dist, n_dist;
    logic        r_dv, n_dv;
    logic        w_in_acc, w_out_acc;
    t_dist_req   w_req;
    t_dist_rsp   w_rsp;
    logic [19:0] w_dist;
    logic [39:0] w_sched_new;
    logic [7:0]  w_rbyte;
    logic [31:0] w_word;

    assign o_ready     = (r_state == S_RX);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && o_ready;
    assign w_out_acc   = r_oval && i_ready;
    assign w_req.start = (r_state == S_CALC) && (r_seq >= 8'd3);
    assign w_sched_new = (r_rxt + {8'd0, r_delay}) & 40'hfffffffe00;

    dstwr_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_ra    (r_round),
        .i_rb    (r_pround),
        .i_da    (r_eown),
        .i_db    (r_pdelay),
        .i_max   (r_maxd),
        .o_rsp   (w_rsp),
        .o_dist  (w_dist)
    );

    // Reply byte selection: word number and lane from the output index.
    always_comb begin
        w_word = '0;
        if (r_oidx >= 5'd1 && r_oidx <= 5'd4)       w_word = r_round;
        else if (r_oidx >= 5'd5 && r_oidx <= 5'd8)  w_word = r_own;
        else if (r_oidx >= 5'd9 && r_oidx <= 5'd12) w_word = r_pdelay;
        w_rbyte = (r_oidx == 5'd0) ? r_seq + 8'd1 : 8'(w_word >> {(r_oidx - 5'd1) & 5'd3, 3'd0});
    end

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_seq = r_seq; n_pround = r_pround;
        n_pdelay = r_pdelay; n_eown = r_eown; n_sched = r_sched; n_rxt = r_rxt;
        n_round = r_round; n_own = r_own; n_st = r_st; n_oidx = r_oidx;
        n_oval = r_oval; n_multi = r_multi; n_dist = r_dist; n_dv = r_dv;
        unique case (r_state)
            S_RX: begin
                if (w_in_acc) begin
                    if (r_cnt < 5'(PACKET_BYTES)) begin
                        if (r_cnt == 5'd0) n_seq = i_rx_byte;
                        else if (r_cnt <= 5'd4)
                            n_pround[{r_cnt[1:0] - 2'd1, 3'd0} +: 8] = i_rx_byte;
                        else if (r_cnt <= 5'd8)
                            n_pdelay[{r_cnt[1:0] - 2'd1, 3'd0} +: 8] = i_rx_byte;
                        else if (r_cnt <= 5'd12)
                            n_eown[{r_cnt[1:0] - 2'd1, 3'd0} +: 8] = i_rx_byte;
                    end
                    n_cnt = (r_cnt < CountSat) ? r_cnt + 5'd1 : r_cnt;
                    if (i_rx_last) begin
                        n_cnt = '0;
                        n_rxt = i_rx_time;
                        n_round = 32'(i_rx_time - r_sched);
                        n_dist = '0; n_dv = 1'b0; n_oidx = '0; n_multi = 1'b0;
                        if (r_cnt + 5'd1 != 5'(PACKET_BYTES) || r_cnt >= CountSat) begin
                            n_st = ST_BADLEN; n_oval = 1'b1; n_state = S_EMIT;
                        end else if (r_is_init != n_seq[0]) begin
                            n_st = ST_PARITY; n_oval = 1'b1; n_state = S_EMIT;
                        end else begin
                            n_state = S_CALC;
                        end
                    end
                end
            end
            S_CALC: begin
                n_state = (r_seq >= 8'd3) ? S_WAIT : S_EMIT;
                if (r_seq < 8'd3) begin
                    n_sched = w_sched_new;
                    n_own = 32'(w_sched_new - r_rxt);
                    n_st = ST_REPLY; n_multi = 1'b1; n_oval = 1'b1;
                end
            end
            S_WAIT: begin
                if (w_rsp.done) begin
                    n_dist = w_dist; n_dv = w_rsp.dv; n_oval = 1'b1;
                    n_state = S_EMIT;
                    if (r_seq >= 8'd4) begin
                        n_st = ST_DONE;
                    end else begin
                        n_sched = w_sched_new;
                        n_own = 32'(w_sched_new - r_rxt);
                        n_st = ST_REPLY; n_multi = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_acc) begin
                    if (!r_multi || r_oidx == 5'(PACKET_BYTES - 1)) begin
                        n_oval = 1'b0; n_state = S_RX;
                    end else begin
                        n_oidx = r_oidx + 5'd1;
                    end
                end
            end
            default: n_state = S_RX;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RX; r_cnt <= '0; r_seq <= '0; r_pround <= '0;
            r_pdelay <= '0; r_eown <= '0; r_sched <= '0; r_oval <= 1'b0;
            r_is_init <= 1'b0; r_delay <= ReplyDelayRst; r_maxd <= MaxDistRst;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_seq <= n_seq;
            r_pround <= n_pround; r_pdelay <= n_pdelay; r_eown <= n_eown;
            r_sched <= n_sched; r_oval <= n_oval;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_INIT:  r_is_init <= i_cfg_data[0];
                    CFG_DELAY: r_delay <= i_cfg_data;
                    CFG_MAXD:  r_maxd <= i_cfg_data[19:0];
                    default: ;
                endcase
            end
        end
        r_rxt <= n_rxt; r_round <= n_round; r_own <= n_own; r_st <= n_st;
        r_oidx <= n_oidx; r_multi <= n_multi; r_dist <= n_dist; r_dv <= n_dv;
    end

    assign o_valid          = r_oval;
    assign o_tx_byte        = r_multi ? w_rbyte : 8'd0;
    assign o_tx_valid       = r_multi;
    assign o_tx_last        = !r_multi || (r_oidx == 5'(PACKET_BYTES - 1));
    assign o_tx_start_time  = r_multi ? r_sched[39:8] : 32'd0;
    assign o_distance_q10   = r_dist;
    assign o_distance_valid = r_dv;
    assign o_status         = r_st;

    // Results are only offered outside the receive state.
    a_no_out_in_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RX |-> !o_valid) else $error("result offered while receiving");
    // A reported distance always lies under the configured limit.
    a_dist_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_distance_valid |-> o_distance_q10 < r_maxd && o_distance_q10 != '0)
        else $error("distance out of range");
    // Status transactions carry no reply byte.
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_REPLY |-> !o_tx_valid && o_tx_last)
        else $error("status transaction malformed");
endmodule
